### rtl/frame_animation_sequencer_top_macros.svh
// assertion helpers for the frame animation sequencer
`ifndef FRAME_ANIMATION_SEQUENCER_TOP_MACROS_SVH
`define FRAME_ANIMATION_SEQUENCER_TOP_MACROS_SVH

// property checked at every clock edge outside reset
`define FAS_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// plain condition that must hold at every clock edge outside reset
`define FAS_ASSERT_ALWAYS(label, expr, msg) \
  `FAS_ASSERT_PROP(label, (expr), msg)

`endif

### rtl/fas_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fas_pkg
// Shared types and constants of the frame animation sequencer.
// ---------------------------------------------------------------------------
package fas_pkg;

  localparam int DIV_W = 23;

  localparam logic [21:0] POS_MAX     = 22'h3FFFFF;
  localparam logic [15:0] LOOP_MAX    = 16'hFFFF;
  localparam logic [15:0] DEFAULT_DUR = 16'd100;

  localparam logic [1:0] PB_STOPPED = 2'd0;
  localparam logic [1:0] PB_PLAYING = 2'd1;
  localparam logic [1:0] PB_PAUSED  = 2'd2;

  localparam logic [1:0] REG_FRAME_COUNT  = 2'd0;
  localparam logic [1:0] REG_LOOP_LIMIT   = 2'd1;
  localparam logic [1:0] REG_FRAME_PERIOD = 2'd2;

  typedef enum logic [3:0] {
    OP_TICK       = 4'd0,
    OP_PLAY       = 4'd1,
    OP_PAUSE      = 4'd2,
    OP_STOP       = 4'd3,
    OP_TOGGLE     = 4'd4,
    OP_SEEK_FRAME = 4'd5,
    OP_SEEK_TIME  = 4'd6,
    OP_STEP_FWD   = 4'd7,
    OP_STEP_BACK  = 4'd8,
    OP_LOAD       = 4'd9
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOTAL,
    S_TOTAL_WALK,
    S_DISPATCH,
    S_WRAP_DIV,
    S_FFP,
    S_FFP_DIV,
    S_FFP_WALK,
    S_STEP_DIV,
    S_GOTO,
    S_GOTO_WALK,
    S_CD,
    S_CD_DIV,
    S_CD_READ,
    S_DONE
  } state_t;

endpackage

### rtl/fas_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fas_div
// Restoring serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fas_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fas_pkg::DIV_W-1:0] dividend,
  input  logic [fas_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [fas_pkg::DIV_W-1:0] quotient,
  output logic [fas_pkg::DIV_W-1:0] remainder
);
  import fas_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W:0]   shifted;
  logic             fits;

  // trial subtract of the shifted partial remainder
  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? DIV_W'(shifted - {1'b0, dsr}) : shifted[DIV_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/frame_animation_sequencer_top.sv
`timescale 1ns / 1ps
// simple operations in period mode pass through the total, dispatch, frame duration
// and done states; table mode walks the duration memory one entry per cycle (total
// length, then frame search or frame start), and divides use the serial divider;
// one request is processed at a time.
// reset is synchronous: playback state and registers clear, table contents stay
// undefined until loaded, no clearing pass
// ---------------------------------------------------------------------------
// frame_animation_sequencer_top
// Millisecond frame animation playback sequencer with a duration table memory.
// ---------------------------------------------------------------------------
`include "frame_animation_sequencer_top_macros.svh"

module frame_animation_sequencer_top #(
  parameter int MAX_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[3:0] frame_number[9:4] time_amount[31:10] frame_duration[47:32]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_index[5:0] frame_changed[6] playback[8:7] finished[9] loops_done[25:10]
  // current_duration[41:26] position_ms[63:42]
  output logic [63:0] m_tdata
);
  import fas_pkg::*;

  localparam int AW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NCAP = (MAX_FRAMES > 127) ? 127 : MAX_FRAMES;

  state_t state, state_next;

  // configuration
  logic [6:0]  frame_count;
  logic [15:0] loop_limit;
  logic [13:0] frame_period;

  // playback state
  logic [21:0] position;
  logic [6:0]  cur_frame;
  logic [15:0] loops_completed;
  logic [1:0]  play_state;
  logic        finished_flag;
  logic [21:0] total;

  // request
  op_t         op;
  logic [5:0]  fnum;
  logic [21:0] amt;
  logic [15:0] dur;
  logic [6:0]  old_frame;
  logic [6:0]  tgt;
  logic [15:0] cur_dur;

  // table walk
  logic [6:0]  iss_i;
  logic [6:0]  dat_i;
  logic [23:0] acc;
  logic        rd_vld;

  // duration memory
  logic [15:0] mem [MAX_FRAMES];
  logic [AW-1:0] rd_addr;
  logic [15:0] rd_data;
  logic        mem_we;

  // divider
  logic             div_start;
  logic [DIV_W-1:0] div_a;
  logic [DIV_W-1:0] div_b;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] div_r;

  // derived values
  logic [6:0]  n_used;
  logic [6:0]  n_last;
  logic        is_tbl;
  logic [22:0] psum;
  logic [15:0] loops_inc;
  logic        tick_run;
  logic        tick_over;
  logic        tick_stop;
  logic        in_walk;
  logic [6:0]  walk_lim;
  logic        issue;
  logic [23:0] rd_sum;
  logic [21:0] rd_sum_sat;
  logic        walk_done;
  logic [6:0]  tgt_clamp;
  logic [20:0] prod_total;
  logic [20:0] prod_goto;
  logic [6:0]  q_clamp;

  assign n_used     = (frame_count > 7'(NCAP)) ? 7'(NCAP) : frame_count;
  assign n_last     = n_used - 7'd1;
  assign is_tbl     = (frame_period == '0);
  assign psum       = {1'b0, position} + {1'b0, amt};
  assign loops_inc  = (loops_completed == LOOP_MAX) ? loops_completed : loops_completed + 16'd1;
  assign tick_run   = (play_state == PB_PLAYING) && (n_used != '0) && (total != '0);
  assign tick_over  = psum >= {1'b0, total};
  assign tick_stop  = tick_over && (loop_limit != '0) && (loops_inc >= loop_limit);
  assign rd_sum     = acc + {8'b0, rd_data};
  assign rd_sum_sat = (rd_sum > {2'b0, POS_MAX}) ? POS_MAX : rd_sum[21:0];
  assign tgt_clamp  = (tgt > n_last) ? n_last : tgt;
  assign prod_total = n_used * frame_period;
  assign prod_goto  = tgt_clamp * frame_period;
  assign q_clamp    = (div_q > {16'b0, n_last}) ? n_last : div_q[6:0];

  // walk bounds and completion
  assign in_walk = (state == S_TOTAL_WALK) || (state == S_FFP_WALK) || (state == S_GOTO_WALK);
  always_comb begin
    walk_lim  = n_used;
    walk_done = 1'b0;
    case (state)
      S_TOTAL_WALK: walk_done = rd_vld && (dat_i == n_last);
      S_FFP_WALK:   walk_done = rd_vld && (({2'b0, position} < rd_sum) || (dat_i == n_last));
      S_GOTO_WALK: begin
        walk_lim  = cur_frame;
        walk_done = rd_vld && (dat_i == cur_frame - 7'd1);
      end
      default: walk_lim = n_used;
    endcase
  end
  assign issue = in_walk && (iss_i < walk_lim);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (s_tvalid) state_next = S_TOTAL;
      S_TOTAL:      state_next = (n_used != '0 && is_tbl) ? S_TOTAL_WALK : S_DISPATCH;
      S_TOTAL_WALK: if (walk_done) state_next = S_DISPATCH;
      S_DISPATCH: begin
        state_next = S_CD;
        case (op)
          OP_TICK: begin
            if (tick_run && !tick_stop) state_next = tick_over ? S_WRAP_DIV : S_FFP;
          end
          OP_SEEK_FRAME, OP_STEP_BACK: if (n_used != '0) state_next = S_GOTO;
          OP_SEEK_TIME: if (total != '0) state_next = S_FFP;
          OP_STEP_FWD:  if (n_used != '0) state_next = S_STEP_DIV;
          default:      state_next = S_CD;
        endcase
      end
      S_WRAP_DIV:  if (div_done) state_next = S_FFP;
      S_FFP:       state_next = is_tbl ? S_FFP_WALK : S_FFP_DIV;
      S_FFP_DIV:   if (div_done) state_next = S_CD;
      S_FFP_WALK:  if (walk_done) state_next = S_CD;
      S_STEP_DIV:  if (div_done) state_next = S_GOTO;
      S_GOTO:      state_next = (is_tbl && tgt_clamp != '0) ? S_GOTO_WALK : S_CD;
      S_GOTO_WALK: if (walk_done) state_next = S_CD;
      S_CD: begin
        if (n_used == '0 || !is_tbl) state_next = S_DONE;
        else if (cur_frame < n_used) state_next = S_CD_READ;
        else state_next = S_CD_DIV;
      end
      S_CD_DIV:  if (div_done) state_next = S_CD_READ;
      S_CD_READ: state_next = S_DONE;
      S_DONE:    if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // control outputs: memory address, divider start and operands, table write, input ready
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    rd_addr   = AW'(iss_i);
    mem_we    = 1'b0;
    s_tready  = (state == S_IDLE);
    unique case (state)
      S_DISPATCH: begin
        if (op == OP_TICK && tick_run && tick_over && !tick_stop) begin
          div_start = 1'b1;
          div_a     = psum;
          div_b     = {1'b0, total};
        end
        if (op == OP_STEP_FWD && n_used != '0) begin
          div_start = 1'b1;
          div_a     = DIV_W'(cur_frame) + DIV_W'(1);
          div_b     = DIV_W'(n_used);
        end
        mem_we = (op == OP_LOAD) && (int'(fnum) < MAX_FRAMES);
      end
      S_FFP: begin
        div_start = !is_tbl;
        div_a     = {1'b0, position};
        div_b     = DIV_W'(frame_period);
      end
      S_CD: begin
        rd_addr   = AW'(cur_frame);
        div_start = (n_used != '0) && is_tbl && (cur_frame >= n_used);
        div_a     = DIV_W'(cur_frame);
        div_b     = DIV_W'(n_used);
      end
      S_CD_DIV: rd_addr = AW'(div_r[6:0]);
      default:  rd_addr = AW'(iss_i);
    endcase
  end

  // duration memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(fnum)] <= (dur > 16'd1) ? dur : DEFAULT_DUR;
    rd_data <= mem[rd_addr];
  end

  fas_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // state register, configuration and walk pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_count  <= '0;
      loop_limit   <= '0;
      frame_period <= '0;
      rd_vld       <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_COUNT:  frame_count  <= cfg_data[6:0];
          REG_LOOP_LIMIT:   loop_limit   <= cfg_data;
          REG_FRAME_PERIOD: frame_period <= cfg_data[13:0];
          default:          frame_count  <= frame_count;
        endcase
      end
    end
  end

  // walk counters and accumulator
  always_ff @(posedge clk) begin
    if (!in_walk) begin
      iss_i <= '0;
      dat_i <= '0;
      acc   <= '0;
    end else begin
      if (issue) iss_i <= iss_i + 7'd1;
      if (rd_vld) begin
        acc   <= rd_sum;
        dat_i <= dat_i + 7'd1;
      end
    end
  end

  // request capture and playback state update
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      cur_frame       <= '0;
      loops_completed <= '0;
      play_state      <= PB_STOPPED;
      finished_flag   <= 1'b0;
      total           <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op        <= op_t'(s_tdata[3:0]);
            fnum      <= s_tdata[9:4];
            amt       <= s_tdata[31:10];
            dur       <= s_tdata[47:32];
            old_frame <= cur_frame;
          end
        end
        S_TOTAL: begin
          if (n_used == '0) total <= '0;
          else if (!is_tbl) total <= 22'(prod_total);
        end
        S_TOTAL_WALK: if (walk_done) total <= rd_sum_sat;
        S_DISPATCH: begin
          case (op)
            OP_TICK: begin
              if (tick_run) begin
                if (tick_over) loops_completed <= loops_inc;
                if (tick_stop) begin
                  position      <= total;
                  cur_frame     <= n_last;
                  play_state    <= PB_STOPPED;
                  finished_flag <= 1'b1;
                end else if (!tick_over) begin
                  position <= psum[21:0];
                end
              end
            end
            OP_PLAY, OP_TOGGLE: begin
              if (op == OP_TOGGLE && play_state == PB_PLAYING) begin
                play_state <= PB_PAUSED;
              end else begin
                play_state <= PB_PLAYING;
                if (finished_flag) begin
                  loops_completed <= '0;
                  finished_flag   <= 1'b0;
                  if (n_used != '0) begin
                    cur_frame <= '0;
                    position  <= '0;
                  end
                end
              end
            end
            OP_PAUSE: play_state <= PB_PAUSED;
            OP_STOP, OP_LOAD: begin
              if (op == OP_STOP) play_state <= PB_STOPPED;
              position        <= '0;
              cur_frame       <= '0;
              loops_completed <= '0;
              finished_flag   <= 1'b0;
            end
            OP_SEEK_FRAME: tgt <= {1'b0, fnum};
            OP_SEEK_TIME:  if (total != '0) position <= (amt > total) ? total : amt;
            OP_STEP_BACK:  tgt <= (cur_frame == '0) ? n_last : cur_frame - 7'd1;
            default:       tgt <= tgt;
          endcase
        end
        S_WRAP_DIV: if (div_done) position <= div_r[21:0];
        S_FFP_DIV:  if (div_done) cur_frame <= q_clamp;
        S_FFP_WALK: if (walk_done) cur_frame <= dat_i;
        S_STEP_DIV: if (div_done) tgt <= div_r[6:0];
        S_GOTO: begin
          cur_frame <= tgt_clamp;
          if (!is_tbl) position <= 22'(prod_goto);
          else if (tgt_clamp == '0) position <= '0;
        end
        S_GOTO_WALK: if (walk_done) position <= rd_sum_sat;
        S_CD: begin
          if (n_used == '0) cur_dur <= DEFAULT_DUR;
          else if (!is_tbl) cur_dur <= {2'b0, frame_period};
        end
        S_CD_READ: cur_dur <= rd_data;
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {position, cur_dur, loops_completed, finished_flag, play_state,
                         (op == OP_TICK) && (cur_frame != old_frame), cur_frame[5:0]};
          end
        end
        default: total <= total;
      endcase
    end
  end

  // checks
  `FAS_ASSERT_PROP(a_div_done_waited, div_done |-> (state == S_WRAP_DIV || state == S_FFP_DIV || state == S_STEP_DIV || state == S_CD_DIV), "divider result with no one waiting")
  `FAS_ASSERT_ALWAYS(a_finished_not_playing, !(finished_flag && play_state == PB_PLAYING), "finished while playing")
  `FAS_ASSERT_PROP(a_accept_starts, (s_tvalid && s_tready) |=> (state == S_TOTAL), "accepted request not processed")
  `FAS_ASSERT_PROP(a_walk_in_range, (rd_vld && in_walk) |-> (dat_i < walk_lim), "table walk past its bound")

endmodule
